// ----- hdl/lle_pkg.sv -----
// Package: sizes, payload types and cell flow types for the LCS length engine.
`timescale 1ns / 1ps
package lle_pkg;

  localparam int unsigned MAX_LEN   = 64;
  localparam int unsigned CNT_W     = $clog2(MAX_LEN + 1);
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned SCORE_W   = 7;
  localparam int unsigned ACT_W     = 2;

  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam score_t SCORE_MAX = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_X   = 2'd0,
    ACT_Y   = 2'd1,
    ACT_FIN = 2'd2
  } action_e;

  // What one cell hands to the next every cycle
  typedef struct packed {
    logic   y_vld;
    logic   fin;
    sym_t   sym;
    score_t above;  // new score of the previous x position
    score_t diag;   // old score of the previous x position
    score_t len;    // result picked up by a finish token
  } flow_t;

  typedef struct packed {
    logic kill;   // drop y beats in flight and zero the score
    logic clr;    // drop the stored x symbol and zero the score
    logic wr_en;  // load a new x symbol
  } cell_ctl_t;

endpackage

// ----- hdl/lle_if.sv -----
// Interfaces: input item channel and result channel.
`timescale 1ns / 1ps
interface lle_in_if;
  import lle_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [SYM_W-1:0]    symbol;

  modport source (output valid, action, symbol, input ready);
  modport sink   (input valid, action, symbol, output ready);
endinterface

interface lle_out_if;
  import lle_pkg::*;
  logic                valid;
  logic                ready;
  logic [SCORE_W-1:0]  lcs_len;
  logic                x_overflow;

  modport source (output valid, lcs_len, x_overflow, input ready);
  modport sink   (input valid, lcs_len, x_overflow, output ready);
endinterface

// ----- hdl/lle_cell.sv -----
// One systolic cell: holds one x symbol and its score, updates on each passing y beat.
`timescale 1ns / 1ps
module lle_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lle_pkg::cell_ctl_t ctl_i,
  input  lle_pkg::sym_t     wr_sym_i,
  input  logic              nxt_xv_i,
  input  lle_pkg::flow_t    flow_i,
  output lle_pkg::flow_t    flow_o,
  output logic              xv_o
);
  import lle_pkg::*;

  logic   xv_q, xv_d;
  sym_t   xs_q, xs_d;
  score_t sc_q, sc_d;
  flow_t  flow_q, flow_d;
  score_t v;
  logic   upd;
  logic   is_last;

  assign upd     = flow_i.y_vld && xv_q;
  assign is_last = xv_q && !nxt_xv_i;

  always_comb begin
    if (xs_q == flow_i.sym) begin
      v = (flow_i.diag >= SCORE_MAX) ? SCORE_MAX : score_t'(flow_i.diag + score_t'(1));
    end else begin
      v = (flow_i.above >= sc_q) ? flow_i.above : sc_q;
    end
  end

  always_comb begin
    xv_d = xv_q;
    xs_d = xs_q;
    sc_d = sc_q;
    if (ctl_i.clr) begin
      xv_d = 1'b0;
    end else if (ctl_i.wr_en) begin
      xv_d = 1'b1;
      xs_d = wr_sym_i;
    end
    if (ctl_i.clr || ctl_i.kill) begin
      sc_d = '0;
    end else if (upd) begin
      sc_d = v;
    end
  end

  always_comb begin
    flow_d       = flow_i;
    flow_d.y_vld = flow_i.y_vld && !ctl_i.kill;
    if (upd) begin
      flow_d.above = v;
      flow_d.diag  = sc_q;
    end
    // the finish token picks up the score of the last loaded x position
    if (flow_i.fin && is_last) begin
      flow_d.len = sc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xv_q   <= 1'b0;
      sc_q   <= '0;
      flow_q <= '0;
    end else begin
      xv_q   <= xv_d;
      sc_q   <= sc_d;
      flow_q <= flow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q <= xs_d;
  end

  assign flow_o = flow_q;
  assign xv_o   = xv_q;

endmodule

// ----- hdl/lle_result_buf.sv -----
// Result buffer: output register plus one hold slot for a result that meets a stall.
`timescale 1ns / 1ps
module lle_result_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_vld_i,
  input  lle_pkg::score_t tok_len_i,
  input  logic            tok_ovf_i,
  lle_out_if.source       out_o,
  output logic            loaded_o
);
  import lle_pkg::*;

  logic   out_vld_q, out_vld_d;
  score_t out_len_q, out_len_d;
  logic   out_ovf_q, out_ovf_d;
  logic   hold_vld_q, hold_vld_d;
  score_t hold_len_q, hold_len_d;
  logic   hold_ovf_q, hold_ovf_d;
  logic   out_free;

  assign out_free = !out_vld_q || out_o.ready;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_len_d  = out_len_q;
    out_ovf_d  = out_ovf_q;
    hold_vld_d = hold_vld_q;
    hold_len_d = hold_len_q;
    hold_ovf_d = hold_ovf_q;
    loaded_o   = 1'b0;
    if (tok_vld_i && out_free) begin
      out_vld_d = 1'b1;
      out_len_d = tok_len_i;
      out_ovf_d = tok_ovf_i;
      loaded_o  = 1'b1;
    end else if (tok_vld_i) begin
      hold_vld_d = 1'b1;
      hold_len_d = tok_len_i;
      hold_ovf_d = tok_ovf_i;
    end else if (hold_vld_q && out_free) begin
      out_vld_d  = 1'b1;
      out_len_d  = hold_len_q;
      out_ovf_d  = hold_ovf_q;
      hold_vld_d = 1'b0;
      loaded_o   = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_len_q  <= out_len_d;
    out_ovf_q  <= out_ovf_d;
    hold_len_q <= hold_len_d;
    hold_ovf_q <= hold_ovf_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.lcs_len    = out_len_q;
  assign out_o.x_overflow = out_ovf_q;

endmodule

// ----- hdl/lcs_length_engine_unit.sv -----
// Top level: LCS length engine built as a row of MAX_LEN systolic cells.
//
// Usage: items arrive on in_i (valid/ready), results leave on out_o.
// Action ACT_X appends an x symbol to the next free cell; when all MAX_LEN
// cells are full the symbol is dropped and the overflow flag is set. Every
// append zeroes the score row and drops y beats still in flight.
// Action ACT_Y sends a y symbol into cell 0; it moves one cell per cycle,
// so y and x beats are taken back to back, one per cycle, if not held off.
// Action ACT_FIN sends a finish token down the row behind the y beats. The
// token takes the score of the last loaded cell and leaves the row after
// passing the register of each cell; the result is then registered into
// the output register or, on a stall, the hold slot. in_i.ready stays low
// from a finish beat until its result is in the output register. The x
// count and overflow flag are cleared when the finish beat is taken; the
// row is cleared as the token leaves. Unknown action codes are taken and ignored.
// If the receiver stalls, one result waits in the output register and the
// next in a hold slot; input keeps flowing meanwhile until another finish.
// Reset clears the x count, the overflow flag, all scores and beats in flight.
`timescale 1ns / 1ps
module lcs_length_engine_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  lle_in_if.sink    in_i,
  lle_out_if.source out_o
);
  import lle_pkg::*;

  cnt_t      x_cnt_q, x_cnt_d;
  logic      drop_q, drop_d;
  logic      busy_q, busy_d;
  logic      fin_ovf_q, fin_ovf_d;
  logic      acc;
  logic      do_x, do_y, do_fin;
  logic      full;
  logic      tok_exit;
  logic      loaded;
  flow_t     flow_w [MAX_LEN+1];
  logic      xv_w   [MAX_LEN+1];
  cell_ctl_t ctl_w  [MAX_LEN];

  assign in_i.ready = !busy_q;
  assign acc        = in_i.valid && in_i.ready;
  assign full       = (x_cnt_q == cnt_t'(MAX_LEN));
  assign tok_exit   = flow_w[MAX_LEN].fin;

  always_comb begin
    do_x   = 1'b0;
    do_y   = 1'b0;
    do_fin = 1'b0;
    case (action_e'(in_i.action))
      ACT_X:   do_x   = acc;
      ACT_Y:   do_y   = acc;
      ACT_FIN: do_fin = acc;
      default: ;
    endcase
  end

  always_comb begin
    flow_w[0]       = '0;
    flow_w[0].y_vld = do_y;
    flow_w[0].fin   = do_fin;
    flow_w[0].sym   = in_i.symbol;
  end

  assign xv_w[MAX_LEN] = 1'b0;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    always_comb begin
      ctl_w[i].kill  = do_x;
      ctl_w[i].clr   = tok_exit;
      ctl_w[i].wr_en = do_x && (x_cnt_q == cnt_t'(i));
    end

    lle_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl_w[i]),
      .wr_sym_i (in_i.symbol),
      .nxt_xv_i (xv_w[i+1]),
      .flow_i   (flow_w[i]),
      .flow_o   (flow_w[i+1]),
      .xv_o     (xv_w[i])
    );
  end

  always_comb begin
    x_cnt_d   = x_cnt_q;
    drop_d    = drop_q;
    busy_d    = busy_q;
    fin_ovf_d = fin_ovf_q;
    if (do_x) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        x_cnt_d = x_cnt_q + cnt_t'(1);
      end
    end
    if (do_fin) begin
      x_cnt_d   = '0;
      drop_d    = 1'b0;
      busy_d    = 1'b1;
      fin_ovf_d = drop_q;
    end
    if (loaded) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_cnt_q <= '0;
      drop_q  <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      x_cnt_q <= x_cnt_d;
      drop_q  <= drop_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_ovf_q <= fin_ovf_d;
  end

  lle_result_buf u_res (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tok_vld_i (tok_exit),
    .tok_len_i (flow_w[MAX_LEN].len),
    .tok_ovf_i (fin_ovf_q),
    .out_o     (out_o),
    .loaded_o  (loaded)
  );

endmodule

// ----- hdl/lle_checker.sv -----
// Checker on the top-level ports of the LCS length engine, with its bind.
`timescale 1ns / 1ps
module lle_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic [lle_pkg::ACT_W-1:0] in_action_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [lle_pkg::SCORE_W-1:0] out_len_i
);
  import lle_pkg::*;

  // a taken finish beat holds off input
  a_fin_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_action_i == ACT_FIN)) |=> !in_ready_i)
    else $error("input not held off after finish beat");

  // a fresh result arrives together with the release of the input side
  a_res_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $rose(in_ready_i))
    else $error("result appeared without finishing a token");

  // input is never held off unless a finish beat was taken earlier
  a_block_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && (in_action_i == ACT_FIN)))
    else $error("input held off without a finish beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_len_i)))
    else $error("stalled result beat changed");

endmodule

bind lcs_length_engine_unit lle_checker u_lle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_len_i   (out_o.lcs_len)
);
